### design/rfe_pkg.sv
// Shared types, constants and helpers of the rotating field evaluator.
// No dependencies; every design module but rfe_checker imports this package.
package rfe_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 16;

    localparam logic [31:0] ANGLE_KEEP = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] TWO_PI_Q29  = 34'sd3373259426;

    localparam logic [47:0] AXIS_RESET = 48'h4000_0000_0000;

    localparam int K1 [3] = '{1, 2, 0};
    localparam int K2 [3] = '{2, 0, 1};

    typedef enum logic [1:0] {
        REG_FIELD  = 2'd0,
        REG_AXIS   = 2'd1,
        REG_STEP   = 2'd2,
        REG_EFIELD = 2'd3
    } rfe_reg_t;

    typedef struct packed {
        logic [2:0][15:0] b;
        logic [2:0][15:0] u;
        logic [2:0][15:0] e;
        logic [31:0]      ps;
        logic [2:0][32:0] uxb;
        logic [2:0][35:0] ud;
    } rfe_cfg_t;

    function automatic logic signed [32:0] atan_turn(input int unsigned i);
        logic signed [32:0] a;
        unique case (i)
            0:  a = 33'sd536870912;
            1:  a = 33'sd316933406;
            2:  a = 33'sd167458907;
            3:  a = 33'sd85004756;
            4:  a = 33'sd42667331;
            5:  a = 33'sd21354465;
            6:  a = 33'sd10679838;
            7:  a = 33'sd5340245;
            8:  a = 33'sd2670163;
            9:  a = 33'sd1335087;
            10: a = 33'sd667544;
            11: a = 33'sd333772;
            12: a = 33'sd166886;
            13: a = 33'sd83443;
            14: a = 33'sd41722;
            15: a = 33'sd20861;
            default: a = 33'sd0;
        endcase
        return a;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
        logic signed [31:0] r;
        priority if (v > 80'sd2147483647)
            r = 32'sh7fff_ffff;
        else if (v < -80'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

### design/rfe_cfg.sv
// Configuration registers and the terms derived from them alone.
// Depends on rfe_pkg.
module rfe_cfg
    import rfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data,
    output rfe_cfg_t    cfg
);

    logic [47:0] field_reg;
    logic [47:0] axis_reg;
    logic [31:0] step_reg;
    logic [47:0] efield_reg;

    logic signed [32:0] uxb_reg  [3];
    logic signed [32:0] uxb_next [3];
    logic signed [19:0] d12_reg;
    logic signed [19:0] d12_next;
    logic signed [35:0] ud_reg   [3];
    logic signed [35:0] ud_next  [3];

    logic signed [15:0] u_s [3];
    logic signed [15:0] b_s [3];
    logic signed [33:0] dot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_reg  <= '0;
            axis_reg   <= AXIS_RESET;
            step_reg   <= '0;
            efield_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (rfe_reg_t'(cfg_index))
                REG_FIELD:  field_reg  <= cfg_data;
                REG_AXIS:   axis_reg   <= cfg_data;
                REG_STEP:   step_reg   <= cfg_data[31:0];
                REG_EFIELD: efield_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            u_s[k] = $signed(axis_reg[16*k +: 16]);
            b_s[k] = $signed(field_reg[16*k +: 16]);
        end
        dot = '0;
        for (int k = 0; k < 3; k++)
        begin
            uxb_next[k] = 33'(u_s[K1[k]]) * 33'(b_s[K2[k]])
                        - 33'(u_s[K2[k]]) * 33'(b_s[K1[k]]);
            dot = dot + 34'(u_s[k]) * 34'(b_s[k]);
        end
        d12_next = 20'((dot + 34'sd8192) >>> 14);
        for (int k = 0; k < 3; k++)
        begin
            ud_next[k] = 36'(u_s[k]) * 36'(d12_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        uxb_reg <= uxb_next;
        d12_reg <= d12_next;
        ud_reg  <= ud_next;
    end

    always_comb
    begin
        cfg.ps = step_reg;
        for (int k = 0; k < 3; k++)
        begin
            cfg.b[k]   = field_reg[16*k +: 16];
            cfg.u[k]   = axis_reg[16*k +: 16];
            cfg.e[k]   = efield_reg[16*k +: 16];
            cfg.uxb[k] = uxb_reg[k];
            cfg.ud[k]  = ud_reg[k];
        end
    end

endmodule

### design/rfe_cordic.sv
// Angle product and pipelined CORDIC, one rotation step per stage.
// Depends on rfe_pkg; carries the position alongside each item.
module rfe_cordic
    import rfe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  logic [31:0]        time_ticks,
    input  logic [31:0]        ps,
    input  logic [2:0][31:0]   pos_in,
    output logic               out_valid,
    output logic signed [19:0] cs,
    output logic signed [19:0] sn,
    output logic [2:0][31:0]   pos_out
);

    logic [31:0]        theta_full;
    logic [31:0]        theta_reg;
    logic               v0_reg;
    logic [2:0][31:0]   pos0_reg;

    logic signed [33:0] x_in [CORDIC_STEPS];
    logic signed [33:0] y_in [CORDIC_STEPS];
    logic signed [32:0] z_in [CORDIC_STEPS];
    logic [1:0]         q_in [CORDIC_STEPS];
    logic               v_in [CORDIC_STEPS];
    logic [2:0][31:0]   p_in [CORDIC_STEPS];

    logic signed [33:0] x_reg [CORDIC_STEPS];
    logic signed [33:0] y_reg [CORDIC_STEPS];
    logic signed [32:0] z_reg [CORDIC_STEPS];
    logic [1:0]         q_reg [CORDIC_STEPS];
    logic               v_reg [CORDIC_STEPS];
    logic [2:0][31:0]   p_reg [CORDIC_STEPS];

    logic signed [19:0] c_r;
    logic signed [19:0] s_r;
    logic signed [19:0] cs_next;
    logic signed [19:0] sn_next;
    logic signed [19:0] cs_reg;
    logic signed [19:0] sn_reg;
    logic               vf_reg;
    logic [2:0][31:0]   pf_reg;

    assign theta_full = ps * time_ticks;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (adv)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            theta_reg <= theta_full & ANGLE_KEEP;
            pos0_reg  <= pos_in;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        logic signed [33:0] dx;
        logic signed [33:0] dy;

        if (i == 0)
        begin : g_first
            assign x_in[i] = CORDIC_GAIN;
            assign y_in[i] = '0;
            assign z_in[i] = signed'({3'b000, theta_reg[29:0]});
            assign q_in[i] = theta_reg[31:30];
            assign v_in[i] = v0_reg;
            assign p_in[i] = pos0_reg;
        end
        else
        begin : g_rest
            assign x_in[i] = x_reg[i-1];
            assign y_in[i] = y_reg[i-1];
            assign z_in[i] = z_reg[i-1];
            assign q_in[i] = q_reg[i-1];
            assign v_in[i] = v_reg[i-1];
            assign p_in[i] = p_reg[i-1];
        end

        assign dx = y_in[i] >>> i;
        assign dy = x_in[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else if (adv)
                v_reg[i] <= v_in[i];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (z_in[i] >= 0)
                begin
                    x_reg[i] <= x_in[i] - dx;
                    y_reg[i] <= y_in[i] + dy;
                    z_reg[i] <= z_in[i] - atan_turn(i);
                end
                else
                begin
                    x_reg[i] <= x_in[i] + dx;
                    y_reg[i] <= y_in[i] - dy;
                    z_reg[i] <= z_in[i] + atan_turn(i);
                end
                q_reg[i] <= q_in[i];
                p_reg[i] <= p_in[i];
            end
        end
    end

    always_comb
    begin
        c_r = 20'((x_reg[CORDIC_STEPS-1] + 34'sd8192) >>> 14);
        s_r = 20'((y_reg[CORDIC_STEPS-1] + 34'sd8192) >>> 14);
        unique case (q_reg[CORDIC_STEPS-1])
            2'd0:
            begin
                cs_next = c_r;
                sn_next = s_r;
            end
            2'd1:
            begin
                cs_next = -s_r;
                sn_next = c_r;
            end
            2'd2:
            begin
                cs_next = -c_r;
                sn_next = -s_r;
            end
            default:
            begin
                cs_next = s_r;
                sn_next = -c_r;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vf_reg <= 1'b0;
        else if (adv)
            vf_reg <= v_reg[CORDIC_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cs_reg <= cs_next;
            sn_reg <= sn_next;
            pf_reg <= p_reg[CORDIC_STEPS-1];
        end
    end

    assign out_valid = vf_reg;
    assign cs        = cs_reg;
    assign sn        = sn_reg;
    assign pos_out   = pf_reg;

endmodule

### design/rfe_field.sv
// Field pipeline: Rodrigues rotation, dB/dt, E, A and phi in ten stages.
// Depends on rfe_pkg; fed by rfe_cordic and rfe_cfg.
module rfe_field
    import rfe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  logic signed [19:0] cs,
    input  logic signed [19:0] sn,
    input  logic [2:0][31:0]   pos,
    input  rfe_cfg_t           cfg,
    output logic               out_valid,
    output logic [2:0][31:0]   mag,
    output logic [2:0][31:0]   elec,
    output logic [2:0][31:0]   pot,
    output logic [31:0]        phi
);

    logic               v_reg [1:10];

    logic [2:0][31:0]   r_d   [1:8];
    logic [2:0][31:0]   mag_d [2:10];
    logic [2:0][31:0]   a_d   [4:10];
    logic [31:0]        phi_d [4:10];

    logic signed [20:0] omc;
    logic signed [35:0] pb_reg  [3];
    logic signed [52:0] px_reg  [3];
    logic signed [56:0] pd_reg  [3];
    logic signed [59:0] sum     [3];
    logic [2:0][31:0]   mag_next;

    logic signed [47:0] um1_reg [3];
    logic signed [47:0] um2_reg [3];
    logic signed [63:0] mr1_reg [3];
    logic signed [63:0] mr2_reg [3];
    logic signed [47:0] er_reg  [3];

    logic signed [49:0] ud4     [3];
    logic signed [64:0] md4     [3];
    logic signed [50:0] esum;
    logic signed [31:0] c_reg   [3];
    logic [2:0][31:0]   a_next;
    logic [31:0]        phi_next;

    logic signed [63:0] cp_reg  [3];
    logic signed [32:0] t_reg   [3];
    logic signed [66:0] tp_reg  [3];
    logic signed [31:0] db_reg  [3];
    logic signed [63:0] dr1_reg [3];
    logic signed [63:0] dr2_reg [3];

    logic signed [64:0] dd10    [3];
    logic signed [31:0] hd      [3];
    logic [2:0][31:0]   elec_reg;
    logic [2:0][31:0]   elec_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 1; s <= 10; s++)
                v_reg[s] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[1] <= in_valid;
            for (int s = 2; s <= 10; s++)
                v_reg[s] <= v_reg[s-1];
        end
    end

    always_comb
    begin
        omc = 21'sd65536 - 21'(cs);
        for (int k = 0; k < 3; k++)
        begin
            sum[k] = (60'(pb_reg[k]) <<< 14) + 60'(px_reg[k]) + 60'(pd_reg[k]);
            mag_next[k] = sat32(80'((sum[k] + 60'sd33554432) >>> 26));

            ud4[k] = 50'(um1_reg[k]) - 50'(um2_reg[k]);
            md4[k] = (65'(mr1_reg[k]) >>> 1) - (65'(mr2_reg[k]) >>> 1);
            a_next[k] = sat32(80'((md4[k] + 65'sd32768) >>> 16));

            dd10[k] = (65'(dr1_reg[k]) >>> 1) - (65'(dr2_reg[k]) >>> 1);
            hd[k] = sat32(80'((dd10[k] + 65'sd32768) >>> 16));
            elec_next[k] = sat32(80'(34'(signed'(cfg.e[k])) * 34'sd16 - 34'(hd[k])));
        end
        esum = 51'(er_reg[0]) + 51'(er_reg[1]) + 51'(er_reg[2]);
        phi_next = sat32(80'((-esum + 51'sd2048) >>> 12));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_d[1] <= pos;
            for (int s = 2; s <= 8; s++)
                r_d[s] <= r_d[s-1];
            mag_d[2] <= mag_next;
            for (int s = 3; s <= 10; s++)
                mag_d[s] <= mag_d[s-1];
            a_d[4]   <= a_next;
            phi_d[4] <= phi_next;
            for (int s = 5; s <= 10; s++)
            begin
                a_d[s]   <= a_d[s-1];
                phi_d[s] <= phi_d[s-1];
            end

            for (int k = 0; k < 3; k++)
            begin
                pb_reg[k] <= 36'(signed'(cfg.b[k])) * 36'(cs);
                px_reg[k] <= 53'(signed'(cfg.uxb[k])) * 53'(sn);
                pd_reg[k] <= 57'(signed'(cfg.ud[k])) * 57'(omc);

                um1_reg[k] <= 48'(signed'(cfg.u[K1[k]])) * 48'(signed'(mag_d[2][K2[k]]));
                um2_reg[k] <= 48'(signed'(cfg.u[K2[k]])) * 48'(signed'(mag_d[2][K1[k]]));
                mr1_reg[k] <= 64'(signed'(mag_d[2][K1[k]])) * 64'(signed'(r_d[2][K2[k]]));
                mr2_reg[k] <= 64'(signed'(mag_d[2][K2[k]])) * 64'(signed'(r_d[2][K1[k]]));
                er_reg[k]  <= 48'(signed'(cfg.e[k])) * 48'(signed'(r_d[2][k]));

                c_reg[k]  <= sat32(80'((ud4[k] + 50'sd8192) >>> 14));
                cp_reg[k] <= 64'(c_reg[k]) * 64'(signed'(cfg.ps));
                t_reg[k]  <= 33'((65'(cp_reg[k]) + 65'sd2147483648) >>> 32);
                tp_reg[k] <= 67'(t_reg[k]) * 67'(TWO_PI_Q29);
                db_reg[k] <= sat32(80'((tp_reg[k] + 67'sd268435456) >>> 29));

                dr1_reg[k] <= 64'(db_reg[K1[k]]) * 64'(signed'(r_d[8][K2[k]]));
                dr2_reg[k] <= 64'(db_reg[K2[k]]) * 64'(signed'(r_d[8][K1[k]]));
            end
            elec_reg <= elec_next;
        end
    end

    assign out_valid = v_reg[10];
    assign mag       = mag_d[10];
    assign elec      = elec_reg;
    assign pot       = a_d[10];
    assign phi       = phi_d[10];

endmodule

### design/rotating_field_evaluator_top.sv
// Rotating field evaluator: one item per clock unless out_ready stalls it. From
// acceptance to result an item passes one angle-product, sixteen CORDIC, one rounding
// and ten field stages. The whole pipeline advances together: while a result
// waits on out_ready, in_ready is low and nothing moves. Configuration writes take
// effect for items accepted from the next cycle on; write only while no item is in
// flight. Depends on rfe_pkg, rfe_cfg, rfe_cordic and rfe_field.
module rotating_field_evaluator_top
    import rfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] time_ticks,
    input  logic [31:0] position_x,
    input  logic [31:0] position_y,
    input  logic [31:0] position_z,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] mag_x,
    output logic [31:0] mag_y,
    output logic [31:0] mag_z,
    output logic [31:0] elec_x,
    output logic [31:0] elec_y,
    output logic [31:0] elec_z,
    output logic [31:0] potential_x,
    output logic [31:0] potential_y,
    output logic [31:0] potential_z,
    output logic [31:0] scalar_potential,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    rfe_cfg_t           cfg;
    logic               adv;
    logic               cv;
    logic signed [19:0] cs;
    logic signed [19:0] sn;
    logic [2:0][31:0]   pos_in;
    logic [2:0][31:0]   pos_c;
    logic [2:0][31:0]   mag;
    logic [2:0][31:0]   elec;
    logic [2:0][31:0]   pot;

    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;
    assign pos_in   = {position_z, position_y, position_x};

    rfe_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rfe_cordic u_cordic (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (in_valid),
        .time_ticks (time_ticks),
        .ps         (cfg.ps),
        .pos_in     (pos_in),
        .out_valid  (cv),
        .cs         (cs),
        .sn         (sn),
        .pos_out    (pos_c)
    );

    rfe_field u_field (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (cv),
        .cs        (cs),
        .sn        (sn),
        .pos       (pos_c),
        .cfg       (cfg),
        .out_valid (out_valid),
        .mag       (mag),
        .elec      (elec),
        .pot       (pot),
        .phi       (scalar_potential)
    );

    assign mag_x       = mag[0];
    assign mag_y       = mag[1];
    assign mag_z       = mag[2];
    assign elec_x      = elec[0];
    assign elec_y      = elec[1];
    assign elec_z      = elec[2];
    assign potential_x = pot[0];
    assign potential_y = pot[1];
    assign potential_z = pot[2];

endmodule

### design/rfe_checker.sv
// Port-level checks of the rotating field evaluator, bound to the top level.
// Depends on rotating_field_evaluator_top's port list only.
module rfe_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] mag_x,
    input logic [31:0] elec_y,
    input logic [31:0] potential_z,
    input logic [31:0] scalar_potential
);

    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow the output stage");

    a_stall_freezes_output: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> $stable(out_valid))
        else $error("output valid moved while the pipeline was stalled");

    a_stalled_item_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(mag_x) && $stable(elec_y)
            && $stable(potential_z) && $stable(scalar_potential))
        else $error("stalled item changed before it was taken");

endmodule

bind rotating_field_evaluator_top rfe_checker u_rfe_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ready         (in_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .mag_x            (mag_x),
    .elec_y           (elec_y),
    .potential_z      (potential_z),
    .scalar_potential (scalar_potential)
);
